[hw/rtl/byte_register_vm_execute_core_assert.svh]
// Assertion macros shared by the byte register VM checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef BYTE_REGISTER_VM_EXECUTE_CORE_ASSERT_SVH
`define BYTE_REGISTER_VM_EXECUTE_CORE_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted
`define BVM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, masked while reset is asserted
`define BVM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/bvm_pkg.sv]
// Shared types and constants for the byte register VM execute core.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package bvm_pkg;

	localparam int PcW      = 12;
	localparam int InsW     = 16;
	localparam int RegW     = 8;
	localparam int RfDepth  = 16;
	localparam int RfAddrW  = $clog2(RfDepth);
	localparam int OutDataW = 32;

	localparam logic [PcW-1:0]     PcReset = PcW'(512);
	localparam logic [PcW-1:0]     PcStep  = PcW'(2);
	localparam logic [RfAddrW-1:0] FlagReg = RfAddrW'(15);

	// Top nibble opcodes
	localparam logic [3:0] OpSys  = 4'h0;
	localparam logic [3:0] OpJump = 4'h1;
	localparam logic [3:0] OpSkEq = 4'h3;
	localparam logic [3:0] OpSkNe = 4'h4;
	localparam logic [3:0] OpSkRr = 4'h5;
	localparam logic [3:0] OpLd   = 4'h6;
	localparam logic [3:0] OpAddI = 4'h7;
	localparam logic [3:0] OpAlu  = 4'h8;

	// Low nibble functions of the register ALU group
	localparam logic [3:0] AluMov = 4'h0;
	localparam logic [3:0] AluOr  = 4'h1;
	localparam logic [3:0] AluAnd = 4'h2;
	localparam logic [3:0] AluXor = 4'h3;
	localparam logic [3:0] AluAdd = 4'h4;

	localparam logic [InsW-1:0] InsRet = 16'h00EE;

	// Write into the register memory, also used as a bypass record
	typedef struct packed {
		logic               we;
		logic [RfAddrW-1:0] idx;
		logic [RegW-1:0]    data;
	} rf_wr_t;

	// Outcome of executing one instruction
	typedef struct packed {
		logic [PcW-1:0]     next_pc;
		logic               aborted;
		logic               reg_written;
		logic [RfAddrW-1:0] reg_index;
		logic [RegW-1:0]    reg_value;
		logic               skipped;
		rf_wr_t             mem_wr;
		logic               flag_we;
		logic [RegW-1:0]    flag_val;
	} exec_res_t;

endpackage

[hw/rtl/bvm_regfile.sv]
// Data register memory: one write port, two registered read ports.
// Per-entry valid bits make unwritten entries read as zero after reset.
`timescale 1ns / 1ps
module bvm_regfile
	import bvm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  rf_wr_t             wr,
	input  logic               rd_en,
	input  logic [RfAddrW-1:0] rd_addr_a,
	input  logic [RfAddrW-1:0] rd_addr_b,
	output logic [RegW-1:0]    rd_data_a,
	output logic [RegW-1:0]    rd_data_b
);

	logic [RegW-1:0]    mem [RfDepth];
	logic [RfDepth-1:0] valid_q;
	logic [RegW-1:0]    rd_a_q;
	logic [RegW-1:0]    rd_b_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.idx] <= wr.data;
		end
	end

	// Track written entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.we) begin
			valid_q[wr.idx] <= 1'b1;
		end
	end

	// Read ports, old data on a same-edge write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_q <= valid_q[rd_addr_a] ? mem[rd_addr_a] : '0;
			rd_b_q <= valid_q[rd_addr_b] ? mem[rd_addr_b] : '0;
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

[hw/rtl/bvm_exec.sv]
// Instruction decode and ALU for the byte register VM execute core.
// Uses bvm_pkg; purely combinational.
`timescale 1ns / 1ps
module bvm_exec
	import bvm_pkg::*;
(
	input  logic [InsW-1:0] ins,
	input  logic [RegW-1:0] vx,
	input  logic [RegW-1:0] vy,
	input  logic [PcW-1:0]  pc,
	input  logic            halted,
	output exec_res_t       res
);

	logic [3:0]         op;
	logic [RfAddrW-1:0] x;
	logic [3:0]         nib;
	logic [RegW-1:0]    kk;
	logic [RegW:0]      sum;
	logic [PcW-1:0]     npc;
	logic               bad;
	logic               skip;
	logic               wr;
	logic               carry_wr;
	logic [RegW-1:0]    wval;

	assign op  = ins[15:12];
	assign x   = ins[11:8];
	assign nib = ins[3:0];
	assign kk  = ins[7:0];
	assign sum = {1'b0, vx} + {1'b0, vy};

	// Decode and compute
	always_comb begin
		npc      = pc + PcStep;
		bad      = 1'b0;
		skip     = 1'b0;
		wr       = 1'b0;
		carry_wr = 1'b0;
		wval     = '0;
		case (op)
			OpSys:  bad = (ins == InsRet);
			OpJump: npc = ins[PcW-1:0];
			OpSkEq: skip = (vx == kk);
			OpSkNe: skip = (vx != kk);
			OpSkRr: begin
				if (nib != 4'h0) begin
					bad = 1'b1;
				end else begin
					skip = (vx == vy);
				end
			end
			OpLd: begin
				wr   = 1'b1;
				wval = kk;
			end
			OpAddI: begin
				wr   = 1'b1;
				wval = vx + kk;
			end
			OpAlu: begin
				wr = 1'b1;
				case (nib)
					AluMov: wval = vy;
					AluOr:  wval = vx | vy;
					AluAnd: wval = vx & vy;
					AluXor: wval = vx ^ vy;
					AluAdd: begin
						carry_wr = 1'b1;
						// carry wins when the target is the flag register
						wval = (x == FlagReg) ? RegW'(sum[RegW]) : sum[RegW-1:0];
					end
					default: begin
						wr  = 1'b0;
						bad = 1'b1;
					end
				endcase
			end
			default: bad = 1'b1;
		endcase
	end

	// Assemble result; a stopped machine reports only its held pc and aborted
	always_comb begin
		res = '0;
		if (halted || bad) begin
			res.next_pc = pc;
			res.aborted = 1'b1;
		end else begin
			res.next_pc     = skip ? npc + PcStep : npc;
			res.reg_written = wr;
			res.reg_index   = wr ? x : '0;
			res.reg_value   = wr ? wval : '0;
			res.skipped     = skip;
			res.mem_wr.we   = wr && (x != FlagReg);
			res.mem_wr.idx  = x;
			res.mem_wr.data = wval;
			res.flag_we     = carry_wr || (wr && (x == FlagReg));
			res.flag_val    = carry_wr ? RegW'(sum[RegW]) : wval;
		end
	end

endmodule

[hw/rtl/byte_register_vm_execute_core.sv]
// Byte register VM execute core: runs one fetched CHIP-8 instruction per
// input transaction against sixteen 8-bit registers and a 12-bit pc.
//
// Channels: s_axis carries the 16-bit instruction, m_axis returns one
// result per instruction (next pc, aborted, register write, skip flag).
// cfg_valid/cfg_data loads the start address into the pc; it is always ready.
// The user must see that the pc is written only while the core is idle; the core has no check for it.
// Path: the register memory is read at the accepting edge, and the
// instruction executes into the output register when the execute stage
// advances.
// Throughput: one instruction per cycle while m_axis_tready is high; a read of
// a register written by the instruction just ahead is bypassed around the memory.
// Register 15 is kept in a flip-flop so that the add with carry retires
// with a single memory write port.
// Reset: registers read as zero, pc is 512, the machine runs.
// Stall: when m_axis_tready is low the output register holds, the execute
// stage holds behind it and s_axis_tready drops once both are full.
// After an unsupported instruction every result reports aborted.
`timescale 1ns / 1ps
module byte_register_vm_execute_core
	import bvm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [InsW-1:0]     s_axis_tdata,   // [15:0] instruction
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// [11:0] next_pc, [12] aborted, [13] reg_written, [17:14] reg_index,
	// [25:18] reg_value, [26] skipped, [31:27] zero
	output logic [OutDataW-1:0] m_axis_tdata,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [PcW-1:0]      cfg_data        // [11:0] start_address
);

	logic            s1_valid_q;
	logic [InsW-1:0] ins_s1;
	rf_wr_t          fwd_s1;
	logic            out_valid_q;
	exec_res_t       out_q;
	logic [PcW-1:0]  pc_q;
	logic            halted_q;
	logic [RegW-1:0] flag_q;

	logic            in_acc;
	logic            s1_adv;
	logic [RegW-1:0] rd_x;
	logic [RegW-1:0] rd_y;
	logic [RegW-1:0] vx;
	logic [RegW-1:0] vy;
	exec_res_t       res;
	rf_wr_t          mem_wr;

	assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || s1_adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// Commit memory write only when the instruction retires
	always_comb begin
		mem_wr    = res.mem_wr;
		mem_wr.we = res.mem_wr.we && s1_adv;
	end

	bvm_regfile u_rf (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (mem_wr),
		.rd_en     (in_acc),
		.rd_addr_a (s_axis_tdata[11:8]),
		.rd_addr_b (s_axis_tdata[7:4]),
		.rd_data_a (rd_x),
		.rd_data_b (rd_y)
	);

	// Operand select: flag register, bypass of the retiring write, memory
	always_comb begin
		if (ins_s1[11:8] == FlagReg) begin
			vx = flag_q;
		end else if (fwd_s1.we && fwd_s1.idx == ins_s1[11:8]) begin
			vx = fwd_s1.data;
		end else begin
			vx = rd_x;
		end
		if (ins_s1[7:4] == FlagReg) begin
			vy = flag_q;
		end else if (fwd_s1.we && fwd_s1.idx == ins_s1[7:4]) begin
			vy = fwd_s1.data;
		end else begin
			vy = rd_y;
		end
	end

	bvm_exec u_exec (
		.ins    (ins_s1),
		.vx     (vx),
		.vy     (vy),
		.pc     (pc_q),
		.halted (halted_q),
		.res    (res)
	);

	// Execute stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	// Execute stage payload and bypass record of the write retiring now
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ins_s1 <= s_axis_tdata;
			fwd_s1 <= mem_wr;
		end
	end

	// Architectural pc, halt flag and register 15
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= PcReset;
			halted_q <= 1'b0;
			flag_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			pc_q <= cfg_data;
		end else if (s1_adv) begin
			pc_q     <= res.next_pc;
			halted_q <= res.aborted;
			if (res.flag_we) begin
				flag_q <= res.flag_val;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_q.skipped, out_q.reg_value, out_q.reg_index,
		out_q.reg_written, out_q.aborted, out_q.next_pc};

endmodule

[hw/rtl/bvm_checker.sv]
// Port-level checker for the byte register VM execute core, bound to it.
// Uses bvm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "byte_register_vm_execute_core_assert.svh"
module bvm_checker
	import bvm_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_axis_tvalid,
	input logic                s_axis_tready,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	input logic [OutDataW-1:0] m_axis_tdata
);

	logic seen_abort_q;
	logic out_acc;

	assign out_acc = m_axis_tvalid && m_axis_tready;

	// Remember that an aborted result has gone out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_abort_q <= 1'b0;
		end else if (out_acc && m_axis_tdata[12]) begin
			seen_abort_q <= 1'b1;
		end
	end

	`BVM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
	`BVM_ASSERT_NOW(a_abort_sticky, m_axis_tvalid && seen_abort_q, m_axis_tdata[12],
		"machine resumed after abort")
	`BVM_ASSERT_NOW(a_abort_quiet, m_axis_tvalid && m_axis_tdata[12],
		m_axis_tdata[26:13] == '0, "aborted result reports a write or skip")
	`BVM_ASSERT_NOW(a_nowrite_zero, m_axis_tvalid && !m_axis_tdata[13],
		m_axis_tdata[25:14] == '0, "register fields set without a write")
	`BVM_ASSERT_NEXT(a_accept_room, s_axis_tvalid && s_axis_tready,
		s_axis_tready || m_axis_tvalid, "input stalled with no result waiting")

endmodule

bind byte_register_vm_execute_core bvm_checker u_bvm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
